### sv/time_table_linear_interpolator_macros.svh
// Assertion macros shared by the time table interpolator.
`ifndef TIME_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TIME_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Checked only outside reset.
`define TTLI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// Checked at every edge, reset included.
`define TTLI_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

### sv/ttli_pkg.sv
// Types, constants and helpers of the time table interpolator.
`default_nettype none
package ttli_pkg;

  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CountW     = AddrW + 1;
  localparam int FracBits   = 16;
  localparam int ValW       = 32;
  localparam int DivNW      = ValW + FracBits;
  localparam int DivCntW    = $clog2(DivNW + 1);
  localparam int ProdW      = 2 * ValW + 1;
  localparam int ShW        = ProdW - FracBits;
  localparam int SumW       = ShW + 1;

  localparam logic [1:0] KindAppend = 2'd0;
  localparam logic [1:0] KindRewind = 2'd1;
  localparam logic [1:0] KindSample = 2'd2;

  localparam logic [1:0] StatSample  = 2'd0;
  localparam logic [1:0] StatStored  = 2'd1;
  localparam logic [1:0] StatDropped = 2'd2;
  localparam logic [1:0] StatRewound = 2'd3;

  localparam logic [1:0] CompLast = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] point_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_beat_t;

  typedef struct packed {
    logic [ValW-1:0] t;
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
    logic [ValW-1:0] z;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ADDR_CUR   = 2'd0,
    ADDR_NEXT  = 2'd1,
    ADDR_COUNT = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    OUT_ZERO = 2'd0,
    OUT_HELD = 2'd1,
    OUT_RES  = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic      in_load;
    logic      ram_we;
    addr_sel_t addr_sel;
    logic      cursor_clr;
    logic      cursor_inc;
    logic      count_inc;
    logic      base_from_q;
    logic      base_from_nxt;
    logic      nxt_from_q;
    logic      held_from_q;
    logic      held_from_nxt;
    logic      held_clr;
    logic      hold_set;
    logic      hold_clr;
    logic      slopes_clr;
    logic      div_start;
    logic      slope_load;
    logic [1:0] comp;
    logic      el_load;
    logic      mul_load;
    logic      res_load;
    logic      out_load;
    logic [1:0] out_status;
    out_sel_t  out_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic count_zero;
    logic count_one;
    logic full;
    logic hold;
    logic has_next;
    logic next_is_last;
    logic later;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [ValW-1:0] sat_val(input logic [SumW-1:0] v);
    logic [ValW-1:0] r;
    if (v[SumW-1:ValW-1] == '0 || v[SumW-1:ValW-1] == '1) begin
      r = v[ValW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      r = {1'b0, {(ValW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/ttli_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ttli_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/ttli_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ttli_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [ttli_pkg::DivNW-1:0]      num,
  input  wire logic [ttli_pkg::ValW-1:0]       den,
  output      logic                            done,
  output      logic [ttli_pkg::DivNW-1:0]      quo
);
  logic                          busy;
  logic [ttli_pkg::DivCntW-1:0]  cnt;
  logic [ttli_pkg::ValW-1:0]     rem;
  logic [ttli_pkg::ValW-1:0]     den_r;
  logic [ttli_pkg::ValW:0]       rem_sh;
  logic [ttli_pkg::ValW+1:0]     diff;

  assign rem_sh = {rem, quo[ttli_pkg::DivNW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= ttli_pkg::DivCntW'(ttli_pkg::DivNW);
        rem   <= '0;
        den_r <= den;
        quo   <= num;
      end else if (busy) begin
        // The remainder stays below the divisor, so it fits the divisor width.
        if (!diff[ttli_pkg::ValW+1]) begin
          rem <= diff[ttli_pkg::ValW-1:0];
          quo <= {quo[ttli_pkg::DivNW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[ttli_pkg::ValW-1:0];
          quo <= {quo[ttli_pkg::DivNW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == ttli_pkg::DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### sv/ttli_ctrl.sv
// Sequencer of the time table interpolator.
`default_nettype none
module ttli_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [1:0]        req_kind,
  output      logic              req_stall,
  input  wire ttli_pkg::sts_t    sts,
  output      ttli_pkg::cmd_t    cmd
);
  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_APPEND  = 18'h00002,
    S_RW_CHK  = 18'h00004,
    S_RW_CAP0 = 18'h00008,
    S_RW_CAP1 = 18'h00010,
    S_DIV_GO  = 18'h00020,
    S_DIV_WT  = 18'h00040,
    S_RW_OUT  = 18'h00080,
    S_SM_CHK  = 18'h00100,
    S_SM_CAP  = 18'h00200,
    S_SM_CMP  = 18'h00400,
    S_SM_RD2  = 18'h00800,
    S_SM_CAP2 = 18'h01000,
    S_EL      = 18'h02000,
    S_MUL     = 18'h04000,
    S_ADD     = 18'h08000,
    S_SM_OUT  = 18'h10000,
    S_HELD    = 18'h20000
  } state_t;

  state_t     state, state_next;
  logic [1:0] comp, comp_next;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp  <= '0;
    end else begin
      state <= state_next;
      comp  <= comp_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.comp   = comp;
    state_next = state;
    comp_next  = comp;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_load = 1'b1;
          priority if (req_kind == ttli_pkg::KindAppend) begin
            state_next = S_APPEND;
          end else if (req_kind == ttli_pkg::KindRewind) begin
            cmd.cursor_clr = 1'b1;
            cmd.slopes_clr = 1'b1;
            state_next     = S_RW_CHK;
          end else if (req_kind == ttli_pkg::KindSample) begin
            state_next = S_SM_CHK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_APPEND: begin
        cmd.addr_sel = ttli_pkg::ADDR_COUNT;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = ttli_pkg::OUT_ZERO;
          if (sts.full) begin
            cmd.out_status = ttli_pkg::StatDropped;
          end else begin
            cmd.ram_we     = 1'b1;
            cmd.count_inc  = 1'b1;
            cmd.out_status = ttli_pkg::StatStored;
          end
          state_next = S_IDLE;
        end
      end
      S_RW_CHK: begin
        if (sts.count_zero) begin
          cmd.held_clr = 1'b1;
          cmd.hold_set = 1'b1;
          state_next   = S_RW_OUT;
        end else begin
          cmd.addr_sel = ttli_pkg::ADDR_CUR;
          state_next   = S_RW_CAP0;
        end
      end
      S_RW_CAP0: begin
        if (sts.count_one) begin
          cmd.held_from_q = 1'b1;
          cmd.hold_set    = 1'b1;
          state_next      = S_RW_OUT;
        end else begin
          cmd.base_from_q = 1'b1;
          cmd.addr_sel    = ttli_pkg::ADDR_NEXT;
          state_next      = S_RW_CAP1;
        end
      end
      S_RW_CAP1: begin
        cmd.nxt_from_q = 1'b1;
        cmd.hold_clr   = 1'b1;
        comp_next      = '0;
        state_next     = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (sts.div_done) begin
          cmd.slope_load = 1'b1;
          if (comp == ttli_pkg::CompLast) begin
            comp_next  = '0;
            state_next = (sts.kind == ttli_pkg::KindRewind) ? S_RW_OUT : S_EL;
          end else begin
            comp_next  = comp + 1'b1;
            state_next = S_DIV_GO;
          end
        end
      end
      S_RW_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ttli_pkg::StatRewound;
          cmd.out_sel    = ttli_pkg::OUT_ZERO;
          state_next     = S_IDLE;
        end
      end
      S_SM_CHK: begin
        if (sts.hold) begin
          state_next = S_HELD;
        end else if (!sts.has_next) begin
          state_next = S_EL;
        end else begin
          cmd.addr_sel = ttli_pkg::ADDR_NEXT;
          state_next   = S_SM_CAP;
        end
      end
      S_SM_CAP: begin
        cmd.nxt_from_q = 1'b1;
        state_next     = S_SM_CMP;
      end
      S_SM_CMP: begin
        comp_next = '0;
        if (sts.later) begin
          cmd.cursor_inc    = 1'b1;
          cmd.base_from_nxt = 1'b1;
          if (sts.next_is_last) begin
            cmd.held_from_nxt = 1'b1;
            cmd.hold_set      = 1'b1;
            cmd.slopes_clr    = 1'b1;
            state_next        = S_HELD;
          end else begin
            state_next = S_SM_RD2;
          end
        end else begin
          state_next = S_EL;
        end
      end
      S_SM_RD2: begin
        cmd.addr_sel = ttli_pkg::ADDR_NEXT;
        state_next   = S_SM_CAP2;
      end
      S_SM_CAP2: begin
        cmd.nxt_from_q = 1'b1;
        state_next     = S_DIV_GO;
      end
      S_EL: begin
        cmd.el_load = 1'b1;
        comp_next   = '0;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_ADD;
      end
      S_ADD: begin
        cmd.res_load = 1'b1;
        if (comp == ttli_pkg::CompLast) begin
          comp_next  = '0;
          state_next = S_SM_OUT;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = S_MUL;
        end
      end
      S_SM_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ttli_pkg::StatSample;
          cmd.out_sel    = ttli_pkg::OUT_RES;
          state_next     = S_IDLE;
        end
      end
      S_HELD: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ttli_pkg::StatSample;
          cmd.out_sel    = ttli_pkg::OUT_HELD;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

### sv/ttli_dp.sv
// Datapath: breakpoint table, cursor, slopes and the interpolation arithmetic.
`default_nettype none
module ttli_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ttli_pkg::in_beat_t   req,
  input  wire ttli_pkg::cmd_t       cmd,
  output      ttli_pkg::sts_t       sts,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_stall,
  output      ttli_pkg::out_beat_t  rsp
);
  localparam int ValW  = ttli_pkg::ValW;
  localparam int AddrW = ttli_pkg::AddrW;

  ttli_pkg::in_beat_t           item;
  logic [ttli_pkg::CountW-1:0]  count;
  logic [AddrW-1:0]             cursor;
  logic                         hold;
  ttli_pkg::entry_t             base;
  ttli_pkg::entry_t             nxt;
  ttli_pkg::entry_t             ram_q;
  ttli_pkg::entry_t             wentry;
  logic [AddrW-1:0]             addr;
  logic [ValW-1:0]              held  [3];
  logic [ValW-1:0]              slope [3];
  logic [ValW-1:0]              res   [3];
  logic signed [ValW:0]         el;
  logic signed [ttli_pkg::ProdW-1:0] prod;
  logic                         neg;
  logic                         dt_zero;

  logic [ValW-1:0]              v0, v1;
  logic [ValW:0]                vdiff, vmag, dt, dmag;
  logic                         div_done;
  logic [ttli_pkg::DivNW-1:0]   quo;
  logic [ValW-1:0]              slope_new;
  logic [ttli_pkg::ProdW-1:0]   adj;
  logic [ttli_pkg::ShW-1:0]     sh;
  logic [ttli_pkg::SumW-1:0]    sum;

  assign wentry = '{t: item.point_time, x: item.point_x, y: item.point_y, z: item.point_z};

  always_comb begin
    unique case (cmd.addr_sel)
      ttli_pkg::ADDR_CUR:   addr = cursor;
      ttli_pkg::ADDR_NEXT:  addr = cursor + 1'b1;
      ttli_pkg::ADDR_COUNT: addr = count[AddrW-1:0];
      default:              addr = cursor;
    endcase
  end

  ttli_ram #(.Width(ttli_pkg::EntryW), .Depth(ttli_pkg::TableDepth)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (addr),
    .wdata (wentry),
    .raddr (addr),
    .rdata (ram_q)
  );

  // Operands of the slope division for the selected component.
  always_comb begin
    unique case (cmd.comp)
      2'd0:    begin v0 = base.x; v1 = nxt.x; end
      2'd1:    begin v0 = base.y; v1 = nxt.y; end
      default: begin v0 = base.z; v1 = nxt.z; end
    endcase
    vdiff = {v1[ValW-1], v1} - {v0[ValW-1], v0};
    vmag  = vdiff[ValW] ? (~vdiff + 1'b1) : vdiff;
    dt    = {nxt.t[ValW-1], nxt.t} - {base.t[ValW-1], base.t};
    dmag  = dt[ValW] ? (~dt + 1'b1) : dt;
  end

  ttli_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({vmag[ValW-1:0], {ttli_pkg::FracBits{1'b0}}}),
    .den   (dmag[ValW-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  // Sign and saturation of the finished quotient.
  always_comb begin
    if (dt_zero) begin
      slope_new = '0;
    end else if (!neg) begin
      slope_new = (quo[ttli_pkg::DivNW-1:ValW-1] != '0) ?
                  {1'b0, {(ValW-1){1'b1}}} : quo[ValW-1:0];
    end else if (quo[ttli_pkg::DivNW-1:ValW] != '0 ||
                 (quo[ValW-1] && quo[ValW-2:0] != '0)) begin
      slope_new = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      slope_new = ~quo[ValW-1:0] + 1'b1;
    end
  end

  // Truncating shift of the product toward zero, then the base is added.
  always_comb begin
    logic [ValW-1:0] bc;
    unique case (cmd.comp)
      2'd0:    bc = base.x;
      2'd1:    bc = base.y;
      default: bc = base.z;
    endcase
    adj = prod + (prod[ttli_pkg::ProdW-1] ?
                  ttli_pkg::ProdW'((1 << ttli_pkg::FracBits) - 1) : '0);
    sh  = adj[ttli_pkg::ProdW-1:ttli_pkg::FracBits];
    sum = {{(ttli_pkg::SumW-ValW){bc[ValW-1]}}, bc} + {sh[ttli_pkg::ShW-1], sh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      hold      <= 1'b1;
      rsp_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        held[i]  <= '0;
        slope[i] <= '0;
      end
    end else begin
      if (cmd.count_inc) count <= count + 1'b1;
      if (cmd.cursor_clr) begin
        cursor <= '0;
      end else if (cmd.cursor_inc) begin
        cursor <= cursor + 1'b1;
      end
      if (cmd.hold_set) begin
        hold <= 1'b1;
      end else if (cmd.hold_clr) begin
        hold <= 1'b0;
      end
      if (cmd.held_clr) begin
        for (int i = 0; i < 3; i++) held[i] <= '0;
      end else if (cmd.held_from_q) begin
        held[0] <= ram_q.x;
        held[1] <= ram_q.y;
        held[2] <= ram_q.z;
      end else if (cmd.held_from_nxt) begin
        held[0] <= nxt.x;
        held[1] <= nxt.y;
        held[2] <= nxt.z;
      end
      if (cmd.slopes_clr) begin
        for (int i = 0; i < 3; i++) slope[i] <= '0;
      end else if (cmd.slope_load) begin
        slope[cmd.comp] <= slope_new;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) item <= req;
    if (cmd.base_from_q) begin
      base <= ram_q;
    end else if (cmd.base_from_nxt) begin
      base <= nxt;
    end
    if (cmd.nxt_from_q) nxt <= ram_q;
    if (cmd.div_start) begin
      neg     <= vdiff[ValW] ^ dt[ValW];
      dt_zero <= (dt == '0);
    end
    if (cmd.el_load) begin
      el <= $signed({item.point_time[ValW-1], item.point_time}) -
            $signed({base.t[ValW-1], base.t});
    end
    if (cmd.mul_load) begin
      prod <= ttli_pkg::ProdW'($signed(slope[cmd.comp])) * ttli_pkg::ProdW'(el);
    end
    if (cmd.res_load) res[cmd.comp] <= ttli_pkg::sat_val(sum);
    if (cmd.out_load) begin
      rsp.status <= cmd.out_status;
      unique case (cmd.out_sel)
        ttli_pkg::OUT_HELD: begin
          rsp.out_x <= held[0];
          rsp.out_y <= held[1];
          rsp.out_z <= held[2];
        end
        ttli_pkg::OUT_RES: begin
          rsp.out_x <= res[0];
          rsp.out_y <= res[1];
          rsp.out_z <= res[2];
        end
        default: begin
          rsp.out_x <= '0;
          rsp.out_y <= '0;
          rsp.out_z <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts              = '0;
    sts.kind         = item.kind;
    sts.count_zero   = (count == '0);
    sts.count_one    = (count == ttli_pkg::CountW'(1));
    sts.full         = (count == ttli_pkg::CountW'(ttli_pkg::TableDepth));
    sts.hold         = hold;
    sts.has_next     = ({1'b0, cursor} + 1'b1) < count;
    sts.next_is_last = ({1'b0, cursor} + ttli_pkg::CountW'(2)) == count;
    sts.later        = $signed(item.point_time) > $signed(nxt.t);
    sts.div_done     = div_done;
    sts.out_free     = !rsp_valid || !rsp_stall;
  end
endmodule
`default_nettype wire

### sv/time_table_linear_interpolator.sv
// Top level of the time table interpolator: sequencer plus datapath.
//
//   channel   direction  handshake              beat type
//   req       in         req_valid / req_stall  ttli_pkg::in_beat_t
//   rsp       out        rsp_valid / rsp_stall  ttli_pkg::out_beat_t
//
// One item at a time. A rewind with two or more points, or a sample that moves to
// a new segment short of the last point, runs the serial divider three times, once
// per component. A result waiting on a stalled rsp holds only the final write; the
// next req beat is taken once the sequencer is idle.
// Reset is synchronous; the table keeps no valid bits and needs no clearing.
`default_nettype none
`include "time_table_linear_interpolator_macros.svh"
module time_table_linear_interpolator (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output      logic                 req_stall,
  input  wire ttli_pkg::in_beat_t   req,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_stall,
  output      ttli_pkg::out_beat_t  rsp
);
  ttli_pkg::cmd_t cmd;
  ttli_pkg::sts_t sts;
  logic           took_item;

  // A beat of a defined kind was accepted at this edge.
  assign took_item = req_valid && !req_stall &&
                     (req.kind == ttli_pkg::KindAppend ||
                      req.kind == ttli_pkg::KindRewind ||
                      req.kind == ttli_pkg::KindSample);

  ttli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttli_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `TTLI_ASSERT(a_no_write_full, cmd.ram_we |-> !sts.full, "table write while full")
  `TTLI_ASSERT(a_busy_after_accept, took_item |=> req_stall, "item taken without going busy")
  `TTLI_ASSERT(a_no_overwrite, cmd.out_load |-> sts.out_free, "result written over a waiting beat")
  `TTLI_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result valid after reset")
endmodule
`default_nettype wire
